FILE: design/e2q_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package e2q_pkg;
   localparam int ANGLE_BITS = 16;
   localparam int FRAC_BITS = 14;
   localparam int CORDIC_STEPS = 16;
   localparam int OUT_BITS = FRAC_BITS + 2;
   localparam int WORK_FRAC = 30;
   localparam int ZW = 41;
   localparam int XW = 33;
   localparam int PW = 32;
   localparam int SW = 34;
   localparam int QDEPTH = 4;
   localparam int QAW = 2;
   localparam logic signed [XW-1:0] CORDIC_GAIN = XW'(652032874);

   typedef struct packed {
      logic [ANGLE_BITS-1:0] roll;
      logic [ANGLE_BITS-1:0] pitch;
      logic [ANGLE_BITS-1:0] yaw;
   } angles_type;

   typedef struct packed {
      logic valid;
      logic almost_full;
   } qstat_type;

   function automatic logic signed [ZW-1:0] atan_entry(input int i);
      logic [31:0] t;
      begin
         case (i)
            0: t = 32'h20000000; 1: t = 32'h12E4051D; 2: t = 32'h09FB385B;
            3: t = 32'h051111D4; 4: t = 32'h028B0D43; 5: t = 32'h0145D7E1;
            6: t = 32'h00A2F61E; 7: t = 32'h00517C55; 8: t = 32'h0028BE53;
            9: t = 32'h00145F2F; 10: t = 32'h000A2F98; 11: t = 32'h000517CC;
            12: t = 32'h00028BE6; 13: t = 32'h000145F3; 14: t = 32'h0000A2F9;
            15: t = 32'h0000517C; 16: t = 32'h000028BE; 17: t = 32'h0000145F;
            18: t = 32'h00000A2F; 19: t = 32'h00000517; 20: t = 32'h0000028B;
            21: t = 32'h00000145; 22: t = 32'h000000A2; 23: t = 32'h00000051;
            24: t = 32'h00000028; 25: t = 32'h00000014; 26: t = 32'h0000000A;
            27: t = 32'h00000005; 28: t = 32'h00000002; 29: t = 32'h00000001;
            default: t = 32'h0;
         endcase
         atan_entry = {1'b0, t, 8'h00};
      end
   endfunction

   function automatic logic signed [OUT_BITS-1:0] finish(input logic signed [SW-1:0] v);
      logic signed [SW-1:0] r;
      begin
         r = (v + SW'(1 << (WORK_FRAC - FRAC_BITS - 1))) >>> (WORK_FRAC - FRAC_BITS);
         if (r > SW'(1 << FRAC_BITS)) r = SW'(1 << FRAC_BITS);
         if (r < -SW'(1 << FRAC_BITS)) r = -SW'(1 << FRAC_BITS);
         finish = r[OUT_BITS-1:0];
      end
   endfunction
endpackage
`default_nettype wire

FILE: design/e2q_front.sv
`timescale 1ns / 1ps
`default_nettype none
module e2q_front (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic push,
   input  wire e2q_pkg::angles_type push_data,
   input  wire logic pop,
   output e2q_pkg::angles_type pop_data,
   output e2q_pkg::qstat_type status
);
   e2q_pkg::angles_type mem_ff [e2q_pkg::QDEPTH];
   logic [e2q_pkg::QAW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [e2q_pkg::QAW:0] cnt_ff, cnt_in;
   logic do_pop;

   assign do_pop = pop && (cnt_ff != '0);
   assign wr_in = push ? wr_ff + 1'b1 : wr_ff;
   assign rd_in = do_pop ? rd_ff + 1'b1 : rd_ff;
   assign cnt_in = cnt_ff + (push ? 1'b1 : 1'b0) - (do_pop ? 1'b1 : 1'b0);
   assign pop_data = mem_ff[rd_ff];
   assign status.valid = cnt_ff != '0;
   assign status.almost_full = cnt_ff >= (e2q_pkg::QAW+1)'(e2q_pkg::QDEPTH - 1);

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_data;
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
   end
endmodule
`default_nettype wire

FILE: design/e2q_back.sv
`timescale 1ns / 1ps
`default_nettype none
module e2q_back (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic in_valid,
   input  wire e2q_pkg::angles_type in_data,
   output logic out_valid,
   output logic signed [e2q_pkg::OUT_BITS-1:0] out_w,
   output logic signed [e2q_pkg::OUT_BITS-1:0] out_x,
   output logic signed [e2q_pkg::OUT_BITS-1:0] out_y,
   output logic signed [e2q_pkg::OUT_BITS-1:0] out_z
);
   localparam int N = e2q_pkg::CORDIC_STEPS;
   localparam int XW = e2q_pkg::XW;
   localparam int ZW = e2q_pkg::ZW;
   localparam int PW = e2q_pkg::PW;
   localparam int L = N + 4;

   logic signed [XW-1:0] x_ff [3][N+1];
   logic signed [XW-1:0] y_ff [3][N+1];
   logic signed [ZW-1:0] z_ff [3][N+1];
   logic [L-1:0] v_ff;
   logic signed [PW-1:0] cr, sr, cp, sp, cy, sy;
   logic signed [PW-1:0] p_ff [4];
   logic signed [PW-1:0] cy_ff, sy_ff;
   logic signed [PW-1:0] t_ff [8];
   logic signed [e2q_pkg::SW-1:0] s_ff [4];
   logic signed [2*PW-1:0] m [12];
   logic [e2q_pkg::ANGLE_BITS-1:0] ang [3];

   assign ang[0] = in_data.roll;
   assign ang[1] = in_data.pitch;
   assign ang[2] = in_data.yaw;

   always_ff @(posedge clock) begin
      for (int a = 0; a < 3; a++) begin
         x_ff[a][0] <= e2q_pkg::CORDIC_GAIN;
         y_ff[a][0] <= '0;
         z_ff[a][0] <= ZW'($signed(ang[a])) <<< (39 - e2q_pkg::ANGLE_BITS);
         for (int i = 0; i < N; i++) begin
            if (!z_ff[a][i][ZW-1]) begin
               x_ff[a][i+1] <= x_ff[a][i] - (y_ff[a][i] >>> i);
               y_ff[a][i+1] <= y_ff[a][i] + (x_ff[a][i] >>> i);
               z_ff[a][i+1] <= z_ff[a][i] - e2q_pkg::atan_entry(i);
            end else begin
               x_ff[a][i+1] <= x_ff[a][i] + (y_ff[a][i] >>> i);
               y_ff[a][i+1] <= y_ff[a][i] - (x_ff[a][i] >>> i);
               z_ff[a][i+1] <= z_ff[a][i] + e2q_pkg::atan_entry(i);
            end
         end
      end
   end

   assign cr = PW'(x_ff[0][N]);
   assign sr = PW'(y_ff[0][N]);
   assign cp = PW'(x_ff[1][N]);
   assign sp = PW'(y_ff[1][N]);
   assign cy = PW'(x_ff[2][N]);
   assign sy = PW'(y_ff[2][N]);

   always_comb begin
      m[0] = cr * cp;
      m[1] = sr * sp;
      m[2] = sr * cp;
      m[3] = cr * sp;
      m[4] = p_ff[0] * cy_ff;
      m[5] = p_ff[1] * sy_ff;
      m[6] = p_ff[2] * cy_ff;
      m[7] = p_ff[3] * sy_ff;
      m[8] = p_ff[3] * cy_ff;
      m[9] = p_ff[2] * sy_ff;
      m[10] = p_ff[0] * sy_ff;
      m[11] = p_ff[1] * cy_ff;
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < 4; k++) p_ff[k] <= PW'(m[k] >>> e2q_pkg::WORK_FRAC);
      cy_ff <= cy;
      sy_ff <= sy;
      for (int k = 0; k < 8; k++) t_ff[k] <= PW'(m[k+4] >>> e2q_pkg::WORK_FRAC);
      s_ff[0] <= e2q_pkg::SW'(t_ff[0]) + e2q_pkg::SW'(t_ff[1]);
      s_ff[1] <= e2q_pkg::SW'(t_ff[2]) - e2q_pkg::SW'(t_ff[3]);
      s_ff[2] <= e2q_pkg::SW'(t_ff[4]) + e2q_pkg::SW'(t_ff[5]);
      s_ff[3] <= e2q_pkg::SW'(t_ff[6]) - e2q_pkg::SW'(t_ff[7]);
      if (reset) v_ff <= '0;
      else v_ff <= {v_ff[L-2:0], in_valid};
   end

   assign out_valid = v_ff[L-1];
   assign out_w = e2q_pkg::finish(s_ff[0]);
   assign out_x = e2q_pkg::finish(s_ff[1]);
   assign out_y = e2q_pkg::finish(s_ff[2]);
   assign out_z = e2q_pkg::finish(s_ff[3]);
endmodule
`default_nettype wire

FILE: design/euler_to_quaternion.sv
`timescale 1ns / 1ps
`default_nettype none
// A request passes the queue register, the angle load register, 16 CORDIC iterations
// and 3 product stages before rsp_valid rises.
// Throughput: one word per cycle; the back end pipeline never stalls.
// The input queue drains at one word per cycle, so busy stays low.
// Reset is synchronous and clears the queue and the pipeline valid bits.
module euler_to_quaternion (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic start,
   output logic busy,
   input  wire logic signed [15:0] req_roll_angle,
   input  wire logic signed [15:0] req_pitch_angle,
   input  wire logic signed [15:0] req_yaw_angle,
   output logic rsp_valid,
   output logic signed [15:0] rsp_quat_w,
   output logic signed [15:0] rsp_quat_x,
   output logic signed [15:0] rsp_quat_y,
   output logic signed [15:0] rsp_quat_z
);
   e2q_pkg::angles_type push_data, pop_data;
   e2q_pkg::qstat_type status;
   logic push;

   assign push = start && !busy;
   assign push_data = '{roll: req_roll_angle, pitch: req_pitch_angle, yaw: req_yaw_angle};
   assign busy = status.almost_full;

   e2q_front u_front (
      .clock(clock), .reset(reset), .push(push), .push_data(push_data),
      .pop(1'b1), .pop_data(pop_data), .status(status)
   );

   e2q_back u_back (
      .clock(clock), .reset(reset), .in_valid(status.valid), .in_data(pop_data),
      .out_valid(rsp_valid), .out_w(rsp_quat_w), .out_x(rsp_quat_x),
      .out_y(rsp_quat_y), .out_z(rsp_quat_z)
   );
endmodule
`default_nettype wire

FILE: design/e2q_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module e2q_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic busy,
   input wire logic rsp_valid,
   input wire logic signed [15:0] rsp_quat_w,
   input wire logic signed [15:0] rsp_quat_x
);
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid && !busy)
      else $error("outputs active after reset");
   a_never_busy: assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy raised");
   a_w_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_quat_w <= 16'sd16384 && rsp_quat_w >= -16'sd16384))
      else $error("w out of range");
   a_x_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_quat_x <= 16'sd16384 && rsp_quat_x >= -16'sd16384))
      else $error("x out of range");
endmodule

bind euler_to_quaternion e2q_checker u_e2q_checker (
   .clock(clock), .reset(reset), .busy(busy),
   .rsp_valid(rsp_valid), .rsp_quat_w(rsp_quat_w), .rsp_quat_x(rsp_quat_x)
);
`default_nettype wire
